// ===== hdl/gls_pkg.sv =====
// package with constants and types for the galloping lower-bound search
package gls_pkg;

    localparam int DEPTH         = 4096;
    localparam int ADDR_W        = $clog2(DEPTH);
    localparam int LINEAR_CUTOFF = 16;
    localparam int FIRST_JUMP    = 4;

    localparam int WORD_W = 32;
    localparam int WADDR_W = 12;
    localparam int POS_W  = 13;
    // probe indices reach begin plus a jump of up to 2^13
    localparam int IDX_W  = 15;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 16;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [POS_W-1:0]  pos_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LAST   = 6'b000010,
        ST_PROBE  = 6'b000100,
        ST_GALLOP = 6'b001000,
        ST_BIN    = 6'b010000,
        ST_LIN    = 6'b100000
    } state_t;

endpackage

// ===== hdl/galloping_lower_bound_search.sv =====
// galloping lower-bound search over a word memory filled by write beats
//
// slave channel (s_tvalid/s_tready/s_tdata/s_tuser) takes one beat per item:
// tuser[0] = 0 writes write_value at write_addr, = 1 runs a search over
// [range_begin, range_end) for the first word at least target.
// master channel (m_tvalid/m_tready/m_tdata/m_tuser) returns one beat per item:
// tuser[0] is the kind, tdata holds the position (zero for a write).
// a write, or a search with an empty or reversed range, is answered in the cycle
// after its beat; other searches do one memory read per cycle through the
// single read port: one check of the last word, up to three head probes,
// about log2(length) gallop steps, halving steps down to a window below
// sixteen words and up to fifteen scan steps.
// one item is in flight at a time; the next beat is taken once the previous
// result sits in the output register and is being taken or gone.
// aresetn (synchronous, active low) returns control to idle and empties the
// output register; memory contents are undefined until written.
// a stalled receiver holds the result in place and blocks new beats.
module galloping_lower_bound_search
    import gls_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // write_addr[11:0], write_value[43:12], range_begin[56:44],
    // range_end[69:57], target[101:70], zero pad[103:102]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // cmd[0]
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // position[12:0], zero pad[15:13]
    output logic [M_TDATA_W-1:0] m_tdata,
    // kind[0]
    output logic [0:0]           m_tuser
);

    // input beat fields
    logic [WADDR_W-1:0] s_write_addr;
    word_t              s_write_value;
    pos_t               s_range_begin;
    pos_t               s_range_end;
    word_t              s_target;

    assign s_write_addr  = s_tdata[11:0];
    assign s_write_value = s_tdata[43:12];
    assign s_range_begin = s_tdata[56:44];
    assign s_range_end   = s_tdata[69:57];
    assign s_target      = s_tdata[101:70];

    // word memory with registered read
    word_t mem [DEPTH];
    word_t rd_data_reg;
    logic  oor_reg;
    idx_t  rd_idx_next;

    // control and search registers
    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   m_kind_reg, m_kind_next;
    pos_t   m_pos_reg, m_pos_next;
    idx_t   begin_reg, begin_next;
    idx_t   end_reg, end_next;
    idx_t   lo_reg, lo_next;
    idx_t   hi_reg, hi_next;
    idx_t   jump_reg, jump_next;
    logic [1:0] k_reg, k_next;
    word_t  target_reg, target_next;

    logic  s_accept;
    logic  wr_en;
    word_t word;
    logic  ge;

    // narrowing entry, shared by probe, gallop and halving exits
    logic  do_narrow;
    idx_t  n_lo, n_hi;
    idx_t  mid;
    idx_t  peek;
    idx_t  jump2;
    idx_t  peek2;
    logic  finish;
    idx_t  fin_pos;

    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign wr_en    = s_accept && (s_tuser[0] == CMD_WRITE)
                      && (32'(s_write_addr) < DEPTH);

    // reads past the memory see zero
    assign word = oor_reg ? '0 : rd_data_reg;
    assign ge   = (word >= target_reg);

    assign mid   = idx_t'((17'(lo_reg) + 17'(hi_reg)) >> 1);
    assign peek  = begin_reg + jump_reg;
    assign jump2 = jump_reg << 1;
    assign peek2 = begin_reg + jump2;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        m_kind_next  = m_kind_reg;
        m_pos_next   = m_pos_reg;
        begin_next   = begin_reg;
        end_next     = end_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        jump_next    = jump_reg;
        k_next       = k_reg;
        target_next  = target_reg;
        rd_idx_next  = '0;
        do_narrow    = 1'b0;
        n_lo         = lo_reg;
        n_hi         = hi_reg;
        finish       = 1'b0;
        fin_pos      = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser[0] == CMD_WRITE) begin
                        m_valid_next = 1'b1;
                        m_kind_next  = CMD_WRITE;
                        m_pos_next   = '0;
                    end else if (s_range_end <= s_range_begin) begin
                        // empty or reversed range answers the end at once
                        m_valid_next = 1'b1;
                        m_kind_next  = CMD_SEARCH;
                        m_pos_next   = s_range_end;
                    end else begin
                        begin_next  = idx_t'(s_range_begin);
                        end_next    = idx_t'(s_range_end);
                        target_next = s_target;
                        rd_idx_next = idx_t'(s_range_end) - idx_t'(1);
                        state_next  = ST_LAST;
                    end
                end
            end
            ST_LAST: begin
                if (!ge) begin
                    finish  = 1'b1;
                    fin_pos = end_reg;
                end else begin
                    k_next      = 2'd0;
                    rd_idx_next = begin_reg;
                    state_next  = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (ge) begin
                    finish  = 1'b1;
                    fin_pos = begin_reg + idx_t'(k_reg);
                end else if (k_reg == 2'd2) begin
                    jump_next = idx_t'(FIRST_JUMP);
                    if (begin_reg + idx_t'(FIRST_JUMP) >= end_reg) begin
                        do_narrow = 1'b1;
                        n_lo      = begin_reg + idx_t'(FIRST_JUMP / 2 + 1);
                        n_hi      = end_reg;
                    end else begin
                        rd_idx_next = begin_reg + idx_t'(FIRST_JUMP);
                        state_next  = ST_GALLOP;
                    end
                end else begin
                    k_next      = k_reg + 2'd1;
                    rd_idx_next = begin_reg + idx_t'(k_reg) + idx_t'(1);
                end
            end
            ST_GALLOP: begin
                if (ge) begin
                    do_narrow = 1'b1;
                    n_lo      = begin_reg + (jump_reg >> 1) + idx_t'(1);
                    n_hi      = peek + idx_t'(1);
                end else begin
                    jump_next = jump2;
                    if (peek2 >= end_reg) begin
                        do_narrow = 1'b1;
                        n_lo      = peek + idx_t'(1);
                        n_hi      = end_reg;
                    end else begin
                        rd_idx_next = peek2;
                    end
                end
            end
            ST_BIN: begin
                do_narrow = 1'b1;
                if (ge) begin
                    n_lo = lo_reg;
                    n_hi = mid;
                end else begin
                    n_lo = mid + idx_t'(1);
                    n_hi = hi_reg;
                end
            end
            ST_LIN: begin
                if (ge) begin
                    finish  = 1'b1;
                    fin_pos = lo_reg;
                end else if (lo_reg + idx_t'(1) < hi_reg) begin
                    lo_next     = lo_reg + idx_t'(1);
                    rd_idx_next = lo_reg + idx_t'(1);
                end else begin
                    finish  = 1'b1;
                    fin_pos = hi_reg;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // pick halving, scan or answer for the new window
        if (do_narrow) begin
            lo_next = n_lo;
            hi_next = n_hi;
            if (n_hi > n_lo && (n_hi - n_lo) >= idx_t'(LINEAR_CUTOFF)) begin
                rd_idx_next = idx_t'((17'(n_lo) + 17'(n_hi)) >> 1);
                state_next  = ST_BIN;
            end else if (n_lo < n_hi) begin
                rd_idx_next = n_lo;
                state_next  = ST_LIN;
            end else begin
                finish  = 1'b1;
                fin_pos = n_hi;
            end
        end

        // output register is empty here: the beat was taken only when it drained
        if (finish) begin
            m_valid_next = 1'b1;
            m_kind_next  = CMD_SEARCH;
            m_pos_next   = pos_t'(fin_pos);
            state_next   = ST_IDLE;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload and search registers
    always_ff @(posedge aclk) begin
        m_kind_reg <= m_kind_next;
        m_pos_reg  <= m_pos_next;
        begin_reg  <= begin_next;
        end_reg    <= end_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        jump_reg   <= jump_next;
        k_reg      <= k_next;
        target_reg <= target_next;
    end

    // memory write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[ADDR_W'(s_write_addr)] <= s_write_value;
        end
        rd_data_reg <= mem[ADDR_W'(rd_idx_next)];
        oor_reg     <= (32'(rd_idx_next) >= DEPTH);
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_pos_reg);
    assign m_tuser  = m_kind_reg;

endmodule
